// File: design/ecu_pkg.sv
// shared constants, codes and types for the easing curve unit
package ecu_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COS_ENTRIES_DEF = 256;

    localparam int FUNC_W = 2;
    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_LINEAR = 2'd0;
    localparam t_func FUNC_COSINE = 2'd1;
    localparam t_func FUNC_QUAD   = 2'd2;
    localparam t_func FUNC_QUART  = 2'd3;

    // pi in q31, used when the cosine table is built
    localparam logic [63:0] PI_Q31  = 64'd6746518852;
    localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;

endpackage

// File: design/ecu_chan_if.sv
// valid/ready channel interfaces for curve requests and results
interface ecu_in_if #(
    parameter int POS_W = 17
);
    import ecu_pkg::*;

    logic             valid;
    logic             ready;
    t_func            func;
    logic [POS_W-1:0] position;

    modport source (output valid, output func, output position, input ready);
    modport sink   (input valid, input func, input position, output ready);
endinterface

interface ecu_out_if #(
    parameter int POS_W = 17
);
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] eased;

    modport source (output valid, output eased, input ready);
    modport sink   (input valid, input eased, output ready);
endinterface

// File: design/easing_curve_unit.sv
// easing curve unit: linear, cosine, quadratic and quartic in-out curves, six-stage pipeline
//
//  channel | dir | transfer when        | payload
//  --------+-----+----------------------+------------------------------------------
//  i_in    | in  | valid & ready        | func (curve select), position (q.FRAC_BITS)
//  o_out   | out | valid & ready        | eased (q.FRAC_BITS, 0 .. 1.0)
//
//  one transfer per cycle sustained while o_out is ready; each transfer passes through all six
//  register stages before o_out.valid rises
//  the six register stages are: saturate/fold, square and table address, table read and
//  rounding, interpolation and fourth-power multiplies, interpolation subtract, curve select
//  i_rst_n (synchronous, active low) clears only the stage valid bits
//  each stage has its own enable, so a stall on o_out only holds occupied stages and
//  bubbles are squeezed out; i_in.ready stays high while any stage ahead can move
module easing_curve_unit #(
    parameter int FRAC_BITS         = ecu_pkg::FRAC_BITS_DEF,
    parameter int COS_TABLE_ENTRIES = ecu_pkg::COS_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ecu_in_if.sink         i_in,
    ecu_out_if.source      o_out
);
    import ecu_pkg::*;

    // widths
    localparam int FW = FRAC_BITS;                      // fraction bits
    localparam int PW = FRAC_BITS + 1;                  // position / result width
    localparam int IW = $clog2(COS_TABLE_ENTRIES + 1);  // table index width
    localparam int AW = FW + IW;                        // table address incl. fraction
    localparam int SW = 2 * FW;                         // square width
    localparam int NST = 6;                             // number of register stages

    localparam logic [PW-1:0] ONE  = PW'(1) << FW;
    localparam logic [PW-1:0] HALF = PW'(1) << (FW - 1);
    localparam logic [AW-1:0] ADDR_MUL  = AW'(2 * COS_TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX  = IW'(COS_TABLE_ENTRIES);
    localparam logic [63:0]   ROM_DIV   = 64'(2 * COS_TABLE_ENTRIES);
    localparam logic [63:0]   ROM_BIAS  = 64'(COS_TABLE_ENTRIES);
    localparam logic [63:0]   ROM_RND   = 64'd1 << (30 - FRAC_BITS);
    localparam int            ROM_SHIFT = 31 - FRAC_BITS;

    typedef logic [PW-1:0] t_rom [0:COS_TABLE_ENTRIES];

    // control and pass-through carried along the pipe
    typedef struct packed {
        t_func         func;
        logic          low;   // position at or below one half
        logic [PW-1:0] x;     // saturated position
    } t_ctl;

    // quarter-wave cosine table, q31 taylor series through t^16 then rounded
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum_u;
        longint      sum;
        for (int k = 0; k <= COS_TABLE_ENTRIES; k++) begin
            theta = (64'(k) * PI_Q31 + ROM_BIAS) / ROM_DIV;
            t2    = (theta * theta) >> 31;
            term  = Q31_ONE;
            sum   = longint'(Q31_ONE);
            term  = ((term * t2) >> 31) / 64'd2;   sum = sum - longint'(term);
            term  = ((term * t2) >> 31) / 64'd12;  sum = sum + longint'(term);
            term  = ((term * t2) >> 31) / 64'd30;  sum = sum - longint'(term);
            term  = ((term * t2) >> 31) / 64'd56;  sum = sum + longint'(term);
            term  = ((term * t2) >> 31) / 64'd90;  sum = sum - longint'(term);
            term  = ((term * t2) >> 31) / 64'd132; sum = sum + longint'(term);
            term  = ((term * t2) >> 31) / 64'd182; sum = sum - longint'(term);
            term  = ((term * t2) >> 31) / 64'd240; sum = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > longint'(Q31_ONE)) begin
                sum = longint'(Q31_ONE);
            end
            sum_u  = 64'(sum);
            rom[k] = PW'((sum_u + ROM_RND) >> ROM_SHIFT);
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = build_rom();

    // ------------------------------------------------------------------
    // stage enables: a stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic [NST:1]   r_v;
    logic [NST+1:1] en;

    always_comb begin
        en[NST+1] = o_out.ready;
        for (int k = NST; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_in.valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // control pipe, consumed by the curve select in the last stage
    t_ctl r_ctl [1:NST-1];

    // ------------------------------------------------------------------
    // stage 1: saturate above one and fold the upper half onto the lower
    // ------------------------------------------------------------------
    t_ctl          n_ctl1;
    logic [FW-1:0] n_u1;
    logic [FW-1:0] r_u1;
    logic [PW-1:0] pos_w;

    always_comb begin
        pos_w        = i_in.position;
        n_ctl1.func  = i_in.func;
        n_ctl1.x     = (pos_w > ONE) ? ONE : pos_w;
        n_ctl1.low   = (n_ctl1.x <= HALF);
        // u never exceeds one half, so it fits the fraction bits
        n_u1         = n_ctl1.low ? n_ctl1.x[FW-1:0] : FW'(ONE - n_ctl1.x);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ctl[1] <= n_ctl1;
            r_u1     <= n_u1;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: u squared and the interpolated table address u * 2N
    // ------------------------------------------------------------------
    logic [SW-1:0] r_sq2;
    logic [AW-1:0] r_addr2;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_ctl[2] <= r_ctl[1];
            r_sq2    <= SW'(r_u1) * SW'(r_u1);
            r_addr2  <= AW'(r_u1) * ADDR_MUL;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: table read of both neighbours, rounding of the squares
    // ------------------------------------------------------------------
    logic [IW-1:0] idx_a;
    logic [IW-1:0] idx_b;
    logic [PW-1:0] tab_a;
    logic [PW-1:0] tab_b;
    logic [SW:0]   quad_sum;
    logic [SW:0]   sq_sum;
    logic [PW-1:0] r_a3;
    logic [PW-1:0] r_diff3;
    logic [FW-1:0] r_frac3;
    logic [FW-1:0] r_q3;
    logic [FW-1:0] r_s3;

    always_comb begin
        idx_a    = r_addr2[AW-1:FW];
        // at the very end of the quarter wave the fraction is zero, so reuse the last entry
        idx_b    = (idx_a == LAST_IDX) ? idx_a : idx_a + IW'(1);
        tab_a    = COS_ROM[idx_a];
        tab_b    = COS_ROM[idx_b];
        if (tab_b > tab_a) begin
            tab_b = tab_a;
        end
        quad_sum = {r_sq2, 1'b0} + (SW+1)'(HALF);
        sq_sum   = {1'b0, r_sq2} + (SW+1)'(HALF);
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_ctl[3] <= r_ctl[2];
            r_a3     <= tab_a;
            r_diff3  <= tab_a - tab_b;
            r_frac3  <= r_addr2[FW-1:0];
            r_q3     <= quad_sum[FW +: FW];
            r_s3     <= sq_sum[FW +: FW];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: interpolation product and s squared for the quartic
    // ------------------------------------------------------------------
    logic [PW+FW-1:0] r_dp4;
    logic [SW-1:0]    r_ss4;
    logic [PW-1:0]    r_a4;
    logic [FW-1:0]    r_q4;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_ctl[4] <= r_ctl[3];
            r_dp4    <= (PW+FW)'(r_diff3) * (PW+FW)'(r_frac3);
            r_ss4    <= SW'(r_s3) * SW'(r_s3);
            r_a4     <= r_a3;
            r_q4     <= r_q3;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: finish the interpolation and the quartic rounding
    // ------------------------------------------------------------------
    logic [SW+2:0] quart_sum;
    logic [PW-1:0] r_c5;
    logic [FW-1:0] r_r5;
    logic [FW-1:0] r_q5;

    always_comb begin
        quart_sum = {r_ss4, 3'b000} + (SW+3)'(HALF);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_ctl[5] <= r_ctl[4];
            r_c5     <= r_a4 - r_dp4[FW +: PW];
            r_r5     <= quart_sum[FW +: FW];
            r_q5     <= r_q4;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: curve select, upper-half mirror and clamp to one
    // ------------------------------------------------------------------
    logic [PW:0]   cos_lo;
    logic [PW:0]   cos_hi;
    logic [PW-1:0] n_y6;
    logic [PW-1:0] r_y6;

    always_comb begin
        cos_lo = ({1'b0, ONE} - {1'b0, r_c5}) >> 1;
        cos_hi = ({1'b0, ONE} + {1'b0, r_c5} + (PW+1)'(1)) >> 1;
        unique case (r_ctl[5].func)
            FUNC_LINEAR: n_y6 = r_ctl[5].x;
            FUNC_COSINE: n_y6 = r_ctl[5].low ? cos_lo[PW-1:0] : cos_hi[PW-1:0];
            FUNC_QUAD:   n_y6 = r_ctl[5].low ? PW'(r_q5) : ONE - PW'(r_q5);
            FUNC_QUART:  n_y6 = r_ctl[5].low ? PW'(r_r5) : ONE - PW'(r_r5);
        endcase
        if (n_y6 > ONE) begin
            n_y6 = ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_y6 <= n_y6;
        end
    end

    assign o_out.valid = r_v[NST];
    assign o_out.eased = r_y6;

endmodule
